[rtl/s128ctr_pkg.sv]
package s128ctr_pkg;

    // Field widths
    localparam int WORD_W    = 64;
    localparam int VALID_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int BYTES     = 2 * WORD_W / 8;

    // Cipher shape: two rounds per key row
    localparam int ROUNDS    = 68;
    localparam int ROW_COUNT = ROUNDS / 2;
    localparam int ROW_W     = $clog2(ROW_COUNT);
    localparam int ROW_DW    = 2 * WORD_W;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROW_COUNT - 1);

    // Key schedule constants
    localparam logic [WORD_W-1:0] SIMON_C  = 64'hffff_ffff_ffff_fffc;
    localparam logic [WORD_W-1:0] SIMON_Z  = 64'h7369_f885_192c_0ef5;
    localparam logic [6:0]        Z_PERIOD = 7'd62;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LO   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HI   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXPAND,
        S_PRIME,
        S_ROUND,
        S_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic             capture;
        logic             load_keys;
        logic             prime;
        logic             expand;
        logic             round;
        logic             load_out;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] rd_row;
    } cmd_t;

    // Round mixing term: (x <<< 1) & (x <<< 8) ^ (x <<< 2)
    function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] r1;
        logic [WORD_W-1:0] r2;
        logic [WORD_W-1:0] r8;
        r1 = {v[62:0], v[63]};
        r2 = {v[61:0], v[63:62]};
        r8 = {v[55:0], v[63:56]};
        return (r1 & r8) ^ r2;
    endfunction

    // One key schedule step from the two previous keys
    function automatic logic [WORD_W-1:0] key_step(input logic [WORD_W-1:0] k_old,
                                                  input logic [WORD_W-1:0] k_new,
                                                  input logic              zbit);
        logic [WORD_W-1:0] r3;
        logic [WORD_W-1:0] r4;
        r3 = {k_new[2:0], k_new[63:3]};
        r4 = {k_new[3:0], k_new[63:4]};
        return SIMON_C ^ {{(WORD_W-1){1'b0}}, zbit} ^ k_old ^ r3 ^ r4;
    endfunction

endpackage

[rtl/s128ctr_if.sv]
interface s128ctr_msg_if;
    logic                               valid;
    logic                               ready;
    logic [s128ctr_pkg::WORD_W-1:0]     data_lo;
    logic [s128ctr_pkg::WORD_W-1:0]     data_hi;
    logic [s128ctr_pkg::VALID_W-1:0]    valid_bytes;
    logic                               first_block;

    modport source (output valid, data_lo, data_hi, valid_bytes, first_block, input ready);
    modport sink   (input valid, data_lo, data_hi, valid_bytes, first_block, output ready);
endinterface

interface s128ctr_res_if;
    logic                               valid;
    logic                               ready;
    logic [s128ctr_pkg::WORD_W-1:0]     result_lo;
    logic [s128ctr_pkg::WORD_W-1:0]     result_hi;

    modport source (output valid, result_lo, result_hi, input ready);
    modport sink   (input valid, result_lo, result_hi, output ready);
endinterface

[rtl/s128ctr_ctrl.sv]
module s128ctr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               msg_valid,
    input  logic               msg_first,
    input  logic               res_ready,
    output logic               msg_ready,
    output logic               res_valid,
    output s128ctr_pkg::cmd_t  cmd
);

    s128ctr_pkg::state_t                 state_reg;
    s128ctr_pkg::state_t                 state_next;
    logic [s128ctr_pkg::ROW_W-1:0]       row_reg;
    logic [s128ctr_pkg::ROW_W-1:0]       row_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic                                out_free;

    assign out_free = !out_valid_reg || res_ready;

    // Hold state, row count and result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= s128ctr_pkg::S_IDLE;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Advance the sequence
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        case (state_reg)
            s128ctr_pkg::S_IDLE:
            begin
                row_next = '0;
                if (msg_valid)
                begin
                    state_next = msg_first ? s128ctr_pkg::S_EXPAND : s128ctr_pkg::S_ROUND;
                end
            end
            s128ctr_pkg::S_EXPAND:
            begin
                if (row_reg == s128ctr_pkg::LAST_ROW)
                begin
                    row_next   = '0;
                    state_next = s128ctr_pkg::S_PRIME;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            s128ctr_pkg::S_PRIME:
            begin
                row_next   = '0;
                state_next = s128ctr_pkg::S_ROUND;
            end
            s128ctr_pkg::S_ROUND:
            begin
                if (row_reg == s128ctr_pkg::LAST_ROW)
                begin
                    row_next   = '0;
                    state_next = s128ctr_pkg::S_DONE;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            s128ctr_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = s128ctr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = s128ctr_pkg::S_IDLE;
                row_next   = '0;
            end
        endcase
    end

    // Drive commands and handshakes
    always_comb
    begin
        msg_ready     = 1'b0;
        cmd           = '0;
        cmd.row       = row_reg;
        case (state_reg)
            s128ctr_pkg::S_IDLE:
            begin
                msg_ready     = 1'b1;
                cmd.capture   = msg_valid;
                cmd.load_keys = msg_valid && msg_first;
                cmd.prime     = msg_valid && !msg_first;
            end
            s128ctr_pkg::S_EXPAND:
            begin
                cmd.expand = 1'b1;
            end
            s128ctr_pkg::S_PRIME:
            begin
                cmd.prime = 1'b1;
            end
            s128ctr_pkg::S_ROUND:
            begin
                cmd.round = 1'b1;
                if (row_reg != s128ctr_pkg::LAST_ROW)
                begin
                    cmd.rd_row = row_reg + 1'b1;
                end
            end
            s128ctr_pkg::S_DONE:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                msg_ready = 1'b0;
            end
        endcase
    end

    // Set the result flag on load, drop it when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign res_valid = out_valid_reg;

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= s128ctr_pkg::LAST_ROW)
        else $error("row count out of range");

    a_last_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == s128ctr_pkg::S_ROUND && row_reg == s128ctr_pkg::LAST_ROW)
        |=> state_reg == s128ctr_pkg::S_DONE)
        else $error("last round did not finish the item");

    a_plain_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == s128ctr_pkg::S_IDLE && msg_valid && !msg_first)
        |=> (state_reg == s128ctr_pkg::S_ROUND && row_reg == '0))
        else $error("item without restart did not enter rounds at row zero");

    a_load_safe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || res_ready))
        else $error("result overwritten before it was taken");

endmodule

[rtl/s128ctr_dp.sv]
module s128ctr_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  s128ctr_pkg::cmd_t                   cmd,
    input  logic                                cfg_wr_en,
    input  logic [s128ctr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [s128ctr_pkg::WORD_W-1:0]      cfg_wdata,
    input  logic [s128ctr_pkg::WORD_W-1:0]      data_lo,
    input  logic [s128ctr_pkg::WORD_W-1:0]      data_hi,
    input  logic [s128ctr_pkg::VALID_W-1:0]     valid_bytes,
    output logic [s128ctr_pkg::WORD_W-1:0]      result_lo,
    output logic [s128ctr_pkg::WORD_W-1:0]      result_hi
);

    logic [s128ctr_pkg::WORD_W-1:0]  key_lo_reg;
    logic [s128ctr_pkg::WORD_W-1:0]  key_hi_reg;
    logic [s128ctr_pkg::WORD_W-1:0]  nonce_lo_reg;
    logic [s128ctr_pkg::WORD_W-1:0]  nonce_hi_reg;
    logic [s128ctr_pkg::WORD_W-1:0]  ctr_reg;

    logic [s128ctr_pkg::WORD_W-1:0]  ka_reg;
    logic [s128ctr_pkg::WORD_W-1:0]  kb_reg;
    logic [s128ctr_pkg::WORD_W-1:0]  ka_next;
    logic [s128ctr_pkg::WORD_W-1:0]  kb_next;

    logic [s128ctr_pkg::WORD_W-1:0]  x_reg;
    logic [s128ctr_pkg::WORD_W-1:0]  y_reg;
    logic [s128ctr_pkg::WORD_W-1:0]  x_next;
    logic [s128ctr_pkg::WORD_W-1:0]  y_next;

    logic [s128ctr_pkg::WORD_W-1:0]  dlo_reg;
    logic [s128ctr_pkg::WORD_W-1:0]  dhi_reg;
    logic [s128ctr_pkg::VALID_W-1:0] vb_reg;
    logic [s128ctr_pkg::WORD_W-1:0]  res_lo_reg;
    logic [s128ctr_pkg::WORD_W-1:0]  res_hi_reg;

    logic [s128ctr_pkg::ROW_DW-1:0]  key_mem [s128ctr_pkg::ROW_COUNT];
    logic [s128ctr_pkg::ROW_DW-1:0]  rk_reg;

    logic [6:0]                      zi_a_raw;
    logic [6:0]                      zi_b_raw;
    logic [5:0]                      zi_a;
    logic [5:0]                      zi_b;
    logic [2*s128ctr_pkg::WORD_W-1:0] byte_mask;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_lo_reg   <= '0;
            key_hi_reg   <= '0;
            nonce_lo_reg <= '0;
            nonce_hi_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                s128ctr_pkg::CFG_KEY_LO:   key_lo_reg   <= cfg_wdata;
                s128ctr_pkg::CFG_KEY_HI:   key_hi_reg   <= cfg_wdata;
                s128ctr_pkg::CFG_NONCE_LO: nonce_lo_reg <= cfg_wdata;
                s128ctr_pkg::CFG_NONCE_HI: nonce_hi_reg <= cfg_wdata;
                default:                   key_lo_reg   <= key_lo_reg;
            endcase
        end
    end

    // Load the counter on restart, advance it per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg <= '0;
        end
        else if (cmd.load_keys)
        begin
            ctr_reg <= nonce_lo_reg;
        end
        else if (cmd.prime)
        begin
            ctr_reg <= ctr_reg + 1'b1;
        end
    end

    // Pick schedule constant bits for the two keys made this cycle
    always_comb
    begin
        zi_a_raw = {cmd.row, 1'b0};
        zi_b_raw = {cmd.row, 1'b1};
        zi_a = (zi_a_raw >= s128ctr_pkg::Z_PERIOD) ? 6'(zi_a_raw - s128ctr_pkg::Z_PERIOD)
                                                   : zi_a_raw[5:0];
        zi_b = (zi_b_raw >= s128ctr_pkg::Z_PERIOD) ? 6'(zi_b_raw - s128ctr_pkg::Z_PERIOD)
                                                   : zi_b_raw[5:0];
        ka_next = s128ctr_pkg::key_step(ka_reg, kb_reg, s128ctr_pkg::SIMON_Z[zi_a]);
        kb_next = s128ctr_pkg::key_step(kb_reg, ka_next, s128ctr_pkg::SIMON_Z[zi_b]);
    end

    // Two Feistel rounds with the current key row
    always_comb
    begin
        y_next = y_reg ^ s128ctr_pkg::mix(x_reg) ^ rk_reg[s128ctr_pkg::WORD_W-1:0];
        x_next = x_reg ^ s128ctr_pkg::mix(y_next)
                 ^ rk_reg[s128ctr_pkg::ROW_DW-1:s128ctr_pkg::WORD_W];
    end

    // Keep byte j while the valid count exceeds j
    always_comb
    begin
        for (int j = 0; j < s128ctr_pkg::BYTES; j++)
        begin
            byte_mask[j*8 +: 8] = {8{vb_reg > s128ctr_pkg::VALID_W'(j)}};
        end
    end

    // Hold item data, key pair, cipher state and result
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            dlo_reg <= data_lo;
            dhi_reg <= data_hi;
            vb_reg  <= valid_bytes;
        end
        if (cmd.load_keys)
        begin
            ka_reg <= key_lo_reg;
            kb_reg <= key_hi_reg;
        end
        else if (cmd.expand)
        begin
            ka_reg <= ka_next;
            kb_reg <= kb_next;
        end
        if (cmd.prime)
        begin
            x_reg <= nonce_hi_reg;
            y_reg <= ctr_reg;
        end
        else if (cmd.round)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
        if (cmd.load_out)
        begin
            res_lo_reg <= (dlo_reg ^ y_reg) & byte_mask[s128ctr_pkg::WORD_W-1:0];
            res_hi_reg <= (dhi_reg ^ x_reg)
                          & byte_mask[2*s128ctr_pkg::WORD_W-1:s128ctr_pkg::WORD_W];
        end
    end

    // Round key memory: one row of two keys written or read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.expand)
        begin
            key_mem[cmd.row] <= {kb_reg, ka_reg};
        end
        rk_reg <= key_mem[cmd.rd_row];
    end

    assign result_lo = res_lo_reg;
    assign result_hi = res_hi_reg;

endmodule

[rtl/simon128_128_ctr_stream_xor.sv]
// Channel   Direction  Payload                                        Handshake
// msg       in         data_lo, data_hi, valid_bytes, first_block     valid / ready
// result    out        result_lo, result_hi                           valid / ready
// cfg       in         cfg_index, cfg_wdata                           cfg_wr_en
//
// An item is accepted, then runs 34 double-round steps through the shared
// round unit reading one key row per cycle, and then loads the result.
// A first_block item first expands the key into the 34-row key memory (two
// keys per row) and then primes the cipher state before its rounds.
// Reset clears control, configuration and counter; round keys hold nothing
// until a first_block item. A result waits in its register until taken; the
// next item is accepted meanwhile, and only its result load waits for space.
module simon128_128_ctr_stream_xor (
    input  logic                               clk,
    input  logic                               rst_n,
    s128ctr_msg_if.sink                        msg,
    s128ctr_res_if.source                      result,
    input  logic                               cfg_wr_en,
    input  logic [s128ctr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [s128ctr_pkg::WORD_W-1:0]     cfg_wdata
);

    s128ctr_pkg::cmd_t cmd;
    logic              msg_ready;
    logic              res_valid;

    // Sequence the item
    s128ctr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg.valid),
        .msg_first (msg.first_block),
        .res_ready (result.ready),
        .msg_ready (msg_ready),
        .res_valid (res_valid),
        .cmd       (cmd)
    );

    // Key schedule, cipher rounds and result masking
    s128ctr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .data_lo     (msg.data_lo),
        .data_hi     (msg.data_hi),
        .valid_bytes (msg.valid_bytes),
        .result_lo   (result.result_lo),
        .result_hi   (result.result_hi)
    );

    assign msg.ready    = msg_ready;
    assign result.valid = res_valid;

endmodule

[tb/sv/tb_simon128_128_ctr_stream_xor.sv]
`timescale 1ns / 1ps

module tb_simon128_128_ctr_stream_xor;

    import s128ctr_pkg::*;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [VALID_W-1:0] nbytes_t;

    typedef struct packed {
        word_t lo;
        word_t hi;
    } ct_words_t;

    typedef enum logic [1:0] {
        ROW_BLOCK,
        ROW_KNOWN,
        ROW_CFG
    } row_kind_t;

    // One line of the directed table: a block, a block with a typed answer, or a register write
    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic                  first;
        nbytes_t               nbytes;
        word_t                 w0;
        word_t                 w1;
        word_t                 exp_lo;
        word_t                 exp_hi;
    } dir_row_t;

    localparam int    NUM_ROUNDS   = 68;
    localparam int    KS_Z_PERIOD  = 62;
    localparam word_t KS_C         = 64'hffff_ffff_ffff_fffc;
    localparam word_t KS_Z         = 64'h7369_f885_192c_0ef5;
    localparam int    TOTAL_BLOCKS = 1350;
    localparam int    DIR_ROWS     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_REGS [4] =
        '{CFG_KEY_LO, CFG_KEY_HI, CFG_NONCE_LO, CFG_NONCE_HI};

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // reset configuration: zero key, zero nonce
        '{ROW_BLOCK, '0, 1'b1, 5'd16, 64'h0, 64'h0, 64'h0, 64'h0},
        '{ROW_BLOCK, '0, 1'b0, 5'd16, '1, '1, 64'h0, 64'h0},
        '{ROW_KNOWN, '0, 1'b0, 5'd0, 64'hdead_beef_0bad_f00d, 64'h0123_4567_89ab_cdef,
          64'h0, 64'h0},
        '{ROW_BLOCK, '0, 1'b0, 5'd31, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
          64'h0, 64'h0},
        '{ROW_BLOCK, '0, 1'b0, 5'd1, '1, '1, 64'h0, 64'h0},
        '{ROW_BLOCK, '0, 1'b0, 5'd8, '1, '1, 64'h0, 64'h0},
        '{ROW_BLOCK, '0, 1'b0, 5'd9, '1, '1, 64'h0, 64'h0},
        '{ROW_BLOCK, '0, 1'b0, 5'd15, 64'ha5a5_a5a5_a5a5_a5a5, 64'h5a5a_5a5a_5a5a_5a5a,
          64'h0, 64'h0},
        // published key and block as key and nonce
        '{ROW_CFG, CFG_KEY_LO, 1'b0, 5'd0, 64'h0706_0504_0302_0100, 64'h0, 64'h0, 64'h0},
        '{ROW_CFG, CFG_KEY_HI, 1'b0, 5'd0, 64'h0f0e_0d0c_0b0a_0908, 64'h0, 64'h0, 64'h0},
        '{ROW_CFG, CFG_NONCE_LO, 1'b0, 5'd0, 64'h6c6c_6576_6172_7420, 64'h0, 64'h0, 64'h0},
        '{ROW_CFG, CFG_NONCE_HI, 1'b0, 5'd0, 64'h6373_6564_2073_7265, 64'h0, 64'h0, 64'h0},
        '{ROW_BLOCK, '0, 1'b1, 5'd16, 64'h0, 64'h0, 64'h0, 64'h0},
        '{ROW_BLOCK, '0, 1'b0, 5'd16, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
          64'h0, 64'h0},
        // all-ones registers: counter starts at its top value and wraps
        '{ROW_CFG, CFG_KEY_LO, 1'b0, 5'd0, '1, 64'h0, 64'h0, 64'h0},
        '{ROW_CFG, CFG_KEY_HI, 1'b0, 5'd0, '1, 64'h0, 64'h0, 64'h0},
        '{ROW_CFG, CFG_NONCE_LO, 1'b0, 5'd0, '1, 64'h0, 64'h0, 64'h0},
        '{ROW_CFG, CFG_NONCE_HI, 1'b0, 5'd0, '1, 64'h0, 64'h0, 64'h0},
        '{ROW_BLOCK, '0, 1'b1, 5'd16, 64'h0, 64'h0, 64'h0, 64'h0},
        '{ROW_BLOCK, '0, 1'b0, 5'd16, 64'h0, 64'h0, 64'h0, 64'h0},
        '{ROW_KNOWN, '0, 1'b0, 5'd0, '1, '1, 64'h0, 64'h0},
        '{ROW_BLOCK, '0, 1'b0, 5'd16, '1, '1, 64'h0, 64'h0},
        // change the nonce inside a message: upper word applies at once
        '{ROW_CFG, CFG_NONCE_LO, 1'b0, 5'd0, 64'hffff_ffff_ffff_fffe, 64'h0, 64'h0, 64'h0},
        '{ROW_CFG, CFG_NONCE_HI, 1'b0, 5'd0, 64'h0, 64'h0, 64'h0, 64'h0},
        '{ROW_BLOCK, '0, 1'b0, 5'd16, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
          64'h0, 64'h0},
        '{ROW_BLOCK, '0, 1'b1, 5'd16, 64'h0, 64'h0, 64'h0, 64'h0},
        '{ROW_BLOCK, '0, 1'b0, 5'd16, 64'h0, 64'h0, 64'h0, 64'h0},
        '{ROW_BLOCK, '0, 1'b0, 5'd16, 64'h0, 64'h0, 64'h0, 64'h0},
        // restart inside a message, then an empty restart block
        '{ROW_BLOCK, '0, 1'b1, 5'd5, '1, '1, 64'h0, 64'h0},
        '{ROW_KNOWN, '0, 1'b1, 5'd0, '1, '1, 64'h0, 64'h0},
        '{ROW_BLOCK, '0, 1'b0, 5'd12, 64'ha5a5_a5a5_a5a5_a5a5, 64'ha5a5_a5a5_a5a5_a5a5,
          64'h0, 64'h0},
        '{ROW_BLOCK, '0, 1'b0, 5'd17, '1, '1, 64'h0, 64'h0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    word_t                 cfg_wdata;

    s128ctr_msg_if msg_ch ();
    s128ctr_res_if res_ch ();

    // Register copies and cipher state of the predictor
    word_t     key_lo_q;
    word_t     key_hi_q;
    word_t     nonce_lo_q;
    word_t     nonce_hi_q;
    word_t     ctr_q;
    word_t     sched [NUM_ROUNDS];

    ct_words_t ct_q [$];
    int        mismatch_cnt = 0;
    int        blocks_sent  = 0;
    bit        msg_calm     = 1'b0;
    bit        res_calm     = 1'b0;
    int        stall_left;
    int        res_cycle;

    simon128_128_ctr_stream_xor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg_ch),
        .result    (res_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic word_t rol(input word_t v, input int unsigned r);
        return (v << r) | (v >> (WORD_W - r));
    endfunction

    function automatic word_t feistel_f(input word_t v);
        return (rol(v, 1) & rol(v, 8)) ^ rol(v, 2);
    endfunction

    function automatic word_t byte_mask(input int unsigned n);
        if (n >= 8)
            return '1;
        return (word_t'(1) << (8 * n)) - word_t'(1);
    endfunction

    // Expand the key registers into the round key schedule
    function automatic void expand_schedule();
        sched[0] = key_lo_q;
        sched[1] = key_hi_q;
        for (int i = 2; i < NUM_ROUNDS; i++)
        begin
            sched[i] = KS_C ^ word_t'(KS_Z[(i - 2) % KS_Z_PERIOD]) ^ sched[i - 2]
                       ^ rol(sched[i - 1], 61) ^ rol(sched[i - 1], 60);
        end
    endfunction

    // Encrypt (nonce_hi, counter), xor into the data, clear bytes past the count
    function automatic ct_words_t ctr_encrypt_block(input word_t d_lo, input word_t d_hi,
                                                    input nbytes_t nb, input logic first);
        word_t       x;
        word_t       y;
        int unsigned n;
        ct_words_t   r;
        if (first)
        begin
            expand_schedule();
            ctr_q = nonce_lo_q;
        end
        x = nonce_hi_q;
        y = ctr_q;
        for (int i = 0; i < NUM_ROUNDS; i += 2)
        begin
            y = y ^ feistel_f(x) ^ sched[i];
            x = x ^ feistel_f(y) ^ sched[i + 1];
        end
        n = (nb > 16) ? 16 : nb;
        r.lo = (d_lo ^ y) & byte_mask(n);
        r.hi = (d_hi ^ x) & ((n > 8) ? byte_mask(n - 8) : '0);
        ctr_q = ctr_q + word_t'(1);
        return r;
    endfunction

    // Mostly short pauses, a few long ones
    function automatic int unsigned pick_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 4);
        if (r < 93)
            return $urandom_range(5, 30);
        return $urandom_range(31, 150);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_KEY_LO:   key_lo_q   = val;
            CFG_KEY_HI:   key_hi_q   = val;
            CFG_NONCE_LO: nonce_lo_q = val;
            CFG_NONCE_HI: nonce_hi_q = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Drop valid and wait for every pending result to be taken
    task automatic wait_idle();
        msg_ch.valid <= 1'b0;
        while (ct_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Offer one block, hold it until accepted, then record its expected result
    task automatic send_block(input word_t d_lo, input word_t d_hi, input nbytes_t nb,
                              input logic first, input bit typed, input ct_words_t typed_ct);
        int unsigned gap;
        ct_words_t   ct;
        gap = (msg_calm || $urandom_range(0, 9) < 4) ? 0 : pick_pause();
        if (gap != 0)
        begin
            msg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_ch.valid       <= 1'b1;
        msg_ch.data_lo     <= d_lo;
        msg_ch.data_hi     <= d_hi;
        msg_ch.valid_bytes <= nb;
        msg_ch.first_block <= first;
        do
            @(posedge clk);
        while (!msg_ch.ready);
        ct = ctr_encrypt_block(d_lo, d_hi, nb, first);
        ct_q.push_back(typed ? typed_ct : ct);
        blocks_sent++;
    endtask

    // Drive result ready with random stalls and stall-free stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_left   <= 0;
            res_cycle    <= 0;
        end
        else
        begin
            res_cycle <= res_cycle + 1;
            if (res_cycle % 512 == 0)
                res_calm <= ($urandom_range(0, 4) == 0);
            if (stall_left != 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end
            else if (!res_calm && $urandom_range(0, 99) < 3)
            begin
                res_ch.ready <= 1'b0;
                stall_left   <= pick_pause();
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        ct_words_t want;
        if (rst_n === 1'b1 && res_ch.valid && res_ch.ready)
        begin
            if (ct_q.size() == 0)
            begin
                $error("result with nothing pending: result_lo=%h result_hi=%h",
                       res_ch.result_lo, res_ch.result_hi);
                mismatch_cnt++;
            end
            else
            begin
                want = ct_q.pop_front();
                if (res_ch.result_lo !== want.lo)
                begin
                    $error("result_lo: expected %h, actual %h", want.lo, res_ch.result_lo);
                    mismatch_cnt++;
                end
                if (res_ch.result_hi !== want.hi)
                begin
                    $error("result_hi: expected %h, actual %h", want.hi, res_ch.result_hi);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int unsigned len;
        bit          resume;
        logic        first;
        nbytes_t     nb;
        word_t       d_lo;
        word_t       d_hi;
        word_t       v;

        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_index          <= CFG_KEY_LO;
        cfg_wdata          <= '0;
        msg_ch.valid       <= 1'b0;
        msg_ch.data_lo     <= '0;
        msg_ch.data_hi     <= '0;
        msg_ch.valid_bytes <= '0;
        msg_ch.first_block <= 1'b0;
        key_lo_q   = '0;
        key_hi_q   = '0;
        nonce_lo_q = '0;
        nonce_hi_q = '0;
        ctr_q      = '0;
        foreach (sched[i])
            sched[i] = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (DIRECTED[k])
        begin
            if (DIRECTED[k].kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(DIRECTED[k].reg_idx, DIRECTED[k].w0);
            end
            else
            begin
                send_block(DIRECTED[k].w0, DIRECTED[k].w1, DIRECTED[k].nbytes,
                           DIRECTED[k].first, DIRECTED[k].kind == ROW_KNOWN,
                           '{lo: DIRECTED[k].exp_lo, hi: DIRECTED[k].exp_hi});
            end
        end

        // Random messages with occasional register changes between them
        while (blocks_sent < TOTAL_BLOCKS)
        begin
            resume = 1'b0;
            if ($urandom_range(0, 7) == 0)
            begin
                wait_idle();
                foreach (CFG_REGS[r])
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        case ($urandom_range(0, 9))
                            0:       v = '0;
                            1:       v = '1;
                            2:       v = '1 - word_t'($urandom_range(0, 5));
                            default: v = {$urandom, $urandom};
                        endcase
                        write_reg(CFG_REGS[r], v);
                    end
                end
                // keep the running message going under the new settings
                resume = ($urandom_range(0, 2) == 0);
            end
            if ($urandom_range(0, 9) == 0)
                msg_calm = !msg_calm;
            case ($urandom_range(0, 19))
                0:          len = $urandom_range(41, 120);
                1, 2, 3, 4: len = $urandom_range(9, 40);
                default:    len = $urandom_range(1, 8);
            endcase
            for (int b = 0; b < len; b++)
            begin
                first = (b == 0 && !resume);
                nb    = (b == len - 1) ? nbytes_t'($urandom_range(1, 16)) : nbytes_t'(16);
                if ($urandom_range(0, 99) < 8)
                    nb = nbytes_t'($urandom_range(0, 31));
                if ($urandom_range(0, 99) < 3)
                    first = 1'b1;
                d_lo = {$urandom, $urandom};
                d_hi = {$urandom, $urandom};
                case ($urandom_range(0, 39))
                    0:       {d_lo, d_hi} = '0;
                    1:       {d_lo, d_hi} = '1;
                    default: ;
                endcase
                send_block(d_lo, d_hi, nb, first, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
rtl/s128ctr_pkg.sv
rtl/s128ctr_if.sv
rtl/s128ctr_ctrl.sv
rtl/s128ctr_dp.sv
rtl/simon128_128_ctr_stream_xor.sv
tb/sv/tb_simon128_128_ctr_stream_xor.sv
